>>> hdl/dgcd_pkg.sv
// Package with the shared constants and types of the directed graph cycle detector.
package dgcd_pkg;

   // Graph size and derived widths.
   localparam int NUM_VERTICES = 128;
   localparam int VERTEX_WIDTH = $clog2(NUM_VERTICES);
   localparam int DEPTH_WIDTH  = $clog2(NUM_VERTICES + 1);

   // Width of the vertex fields on the request channel.
   localparam int FIELD_WIDTH = 7;

   // The first-set search works on groups of this many bits.
   localparam int GROUP_SIZE  = 8;
   localparam int LOCAL_WIDTH = $clog2(GROUP_SIZE);
   localparam int NUM_GROUPS  = (NUM_VERTICES + GROUP_SIZE - 1) / GROUP_SIZE;

   // Edit operation codes.
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef logic [NUM_VERTICES-1:0] vertex_row_type;
   typedef logic [VERTEX_WIDTH-1:0] vertex_idx_type;
   typedef logic [FIELD_WIDTH-1:0]  vertex_field_type;
   typedef logic [DEPTH_WIDTH-1:0]  depth_type;

   // Write request into the adjacency store.
   typedef struct packed {
      logic           en;
      vertex_idx_type addr;
      vertex_row_type row;
   } adj_write_type;

   // Answer of the first-set search.
   typedef struct packed {
      logic           found;
      vertex_idx_type index;
   } first_set_type;

endpackage

>>> hdl/dgcd_channels.sv
// Interfaces of the request and response channels.
interface dgcd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   dgcd_pkg::vertex_field_type from_vertex;
   dgcd_pkg::vertex_field_type to_vertex;

   modport source (output valid, output op, output from_vertex, output to_vertex,
                   input ready);
   modport sink   (input valid, input op, input from_vertex, input to_vertex,
                   output ready);
endinterface

interface dgcd_rsp_if;
   logic valid;
   logic ready;
   logic cycle_present;

   modport source (output valid, output cycle_present, input ready);
   modport sink   (input valid, input cycle_present, output ready);
endinterface

>>> hdl/directed_graph_cycle_detector_unit.sv
// Top level of the directed graph cycle detector: edit sequencer and depth-first search.
//
// Channel   Direction  Payload                          Transfer
// req_if    in         op, from_vertex, to_vertex       valid && ready
// rsp_if    out        cycle_present                    valid && ready
//
// The search that follows an edit ends early when a cycle turns up. Each step of it waits
// on the registered read of the adjacency memory and on the registered first-set unit.
// Reset clears the graph at once through per-row valid bits; no clearing pass is needed.
// A new request is taken only when the search is idle; a finished result waits in the
// output register, and a second result waits in the done state until it is taken.
module directed_graph_cycle_detector_unit (
   input  logic       clock,
   input  logic       reset,
   dgcd_req_if.sink   req_if,
   dgcd_rsp_if.source rsp_if
);
   import dgcd_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_EDIT      = 3'd1;
   localparam logic [2:0] ST_ROOT      = 3'd2;
   localparam logic [2:0] ST_ROOT_PICK = 3'd3;
   localparam logic [2:0] ST_SCAN_RD   = 3'd4;
   localparam logic [2:0] ST_SCAN_PICK = 3'd5;
   localparam logic [2:0] ST_POP_RD    = 3'd6;
   localparam logic [2:0] ST_DONE      = 3'd7;

   logic [2:0]     state_ff, state_in;
   logic           op_ff;
   vertex_idx_type from_ff;
   vertex_idx_type to_ff;
   vertex_row_type visited_ff, visited_in;
   vertex_row_type on_path_ff, on_path_in;
   depth_type      depth_ff, depth_in;
   vertex_idx_type top_ff, top_in;
   logic           result_ff, result_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_data_ff, rsp_data_in;

   logic           req_accept;
   logic           req_in_range;
   vertex_row_type edit_mask;

   adj_write_type  adj_wr;
   vertex_idx_type adj_rd_addr;
   vertex_row_type adj_rd_row;

   logic           stack_we;
   vertex_idx_type stack_waddr;
   vertex_idx_type stack_wdata;
   vertex_idx_type stack_raddr;
   vertex_idx_type stack_rdata;

   vertex_row_type ffs_vec;
   first_set_type  ffs_res;

   // Adjacency rows, the search stack and the first-set unit.
   dgcd_adj_store u_adj_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (adj_wr),
      .rd_addr (adj_rd_addr),
      .rd_row  (adj_rd_row)
   );

   dgcd_ram #(
      .WIDTH (VERTEX_WIDTH),
      .DEPTH (NUM_VERTICES)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   dgcd_first_set u_first_set (
      .clock  (clock),
      .vec    (ffs_vec),
      .result (ffs_res)
   );

   // Request handshake and range check of the edited edge.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign req_in_range = (int'(req_if.from_vertex) < NUM_VERTICES) &&
                         (int'(req_if.to_vertex) < NUM_VERTICES);
   assign edit_mask    = vertex_row_type'(1) << to_ff;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.cycle_present = rsp_data_ff;

   // Sequencer: edit the row, then search from each unvisited vertex in turn.
   always_comb begin
      state_in     = state_ff;
      visited_in   = visited_ff;
      on_path_in   = on_path_ff;
      depth_in     = depth_ff;
      top_in       = top_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      adj_wr.en    = 1'b0;
      adj_wr.addr  = from_ff;
      adj_wr.row   = adj_rd_row | edit_mask;
      adj_rd_addr  = top_ff;
      stack_we     = 1'b0;
      stack_waddr  = VERTEX_WIDTH'(depth_ff);
      stack_wdata  = ffs_res.index;
      stack_raddr  = VERTEX_WIDTH'(depth_ff - DEPTH_WIDTH'(2));
      ffs_vec      = adj_rd_row & ~visited_ff;

      unique case (state_ff)
         ST_IDLE: begin
            adj_rd_addr = VERTEX_WIDTH'(req_if.from_vertex);
            if (req_accept) begin
               visited_in = '0;
               on_path_in = '0;
               depth_in   = '0;
               state_in   = req_in_range ? ST_EDIT : ST_ROOT;
            end
         end
         ST_EDIT: begin
            adj_wr.en = 1'b1;
            if (op_ff == OP_REMOVE) begin
               adj_wr.row = adj_rd_row & ~edit_mask;
            end
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            ffs_vec  = ~visited_ff;
            state_in = ST_ROOT_PICK;
         end
         ST_ROOT_PICK: begin
            if (!ffs_res.found) begin
               result_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               visited_in[ffs_res.index] = 1'b1;
               on_path_in[ffs_res.index] = 1'b1;
               stack_we    = 1'b1;
               depth_in    = depth_ff + DEPTH_WIDTH'(1);
               top_in      = ffs_res.index;
               adj_rd_addr = ffs_res.index;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            // An edge back onto the current path closes a cycle.
            if (|(adj_rd_row & on_path_ff)) begin
               result_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_SCAN_PICK;
            end
         end
         ST_SCAN_PICK: begin
            if (ffs_res.found) begin
               visited_in[ffs_res.index] = 1'b1;
               on_path_in[ffs_res.index] = 1'b1;
               stack_we    = 1'b1;
               depth_in    = depth_ff + DEPTH_WIDTH'(1);
               top_in      = ffs_res.index;
               adj_rd_addr = ffs_res.index;
               state_in    = ST_SCAN_RD;
            end else begin
               // All successors done: leave this vertex and return to its parent.
               on_path_in[top_ff] = 1'b0;
               depth_in = depth_ff - DEPTH_WIDTH'(1);
               state_in = (depth_ff == DEPTH_WIDTH'(1)) ? ST_ROOT : ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            top_in      = stack_rdata;
            adj_rd_addr = stack_rdata;
            state_in    = ST_SCAN_RD;
         end
         ST_DONE: begin
            depth_in   = '0;
            on_path_in = '0;
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         on_path_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         on_path_ff   <= on_path_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and search data registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_if.op;
         from_ff <= VERTEX_WIDTH'(req_if.from_vertex);
         to_ff   <= VERTEX_WIDTH'(req_if.to_vertex);
      end
      visited_ff  <= visited_in;
      top_ff      <= top_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A request is only taken with an empty search stack.
   assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> (depth_ff == '0))
      else $error("request taken while the search stack is not empty");

   // The on-path marks and the stack depth move together.
   assert property (@(posedge clock) disable iff (reset)
      $countones(on_path_ff) == int'(depth_ff))
      else $error("on-path marks disagree with the stack depth");

   // Every vertex on the path has been visited.
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> (on_path_ff & ~visited_ff) == '0)
      else $error("vertex on the path without a visited mark");

   // A response appears only out of the done state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

endmodule

>>> hdl/dgcd_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
module dgcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read, read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/dgcd_adj_store.sv
// Adjacency matrix memory, one row per source vertex, with per-row valid bits.
module dgcd_adj_store (
   input  logic                    clock,
   input  logic                    reset,
   input  dgcd_pkg::adj_write_type wr,
   input  dgcd_pkg::vertex_idx_type rd_addr,
   output dgcd_pkg::vertex_row_type rd_row
);
   import dgcd_pkg::*;

   vertex_row_type              mem [NUM_VERTICES];
   vertex_row_type              mem_rd_ff;
   logic [NUM_VERTICES-1:0]     row_valid_ff;
   logic                        rd_valid_ff;

   // Row storage with registered read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.row;
      end
      mem_rd_ff <= mem[rd_addr];
   end

   // A row that was never written since reset reads as empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr.en) begin
            row_valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_row = rd_valid_ff ? mem_rd_ff : '0;

endmodule

>>> hdl/dgcd_first_set.sv
// Search for the lowest set bit of a vertex vector, with registered group results.
module dgcd_first_set (
   input  logic                     clock,
   input  dgcd_pkg::vertex_row_type vec,
   output dgcd_pkg::first_set_type  result
);
   import dgcd_pkg::*;

   localparam int PadWidth = NUM_GROUPS * GROUP_SIZE;

   logic [PadWidth-1:0]    padded;
   logic [NUM_GROUPS-1:0]  grp_any_in;
   logic [NUM_GROUPS-1:0]  grp_any_ff;
   logic [LOCAL_WIDTH-1:0] grp_idx_in [NUM_GROUPS];
   logic [LOCAL_WIDTH-1:0] grp_idx_ff [NUM_GROUPS];

   assign padded = PadWidth'(vec);

   // First stage: per group, whether any bit is set and the lowest one.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_in[g] = |padded[g*GROUP_SIZE +: GROUP_SIZE];
         grp_idx_in[g] = '0;
         for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
            if (padded[g*GROUP_SIZE + b]) begin
               grp_idx_in[g] = LOCAL_WIDTH'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      grp_idx_ff <= grp_idx_in;
   end

   // Second stage: pick the lowest group that has a set bit.
   always_comb begin
      result.found = |grp_any_ff;
      result.index = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            result.index = VERTEX_WIDTH'(g * GROUP_SIZE + int'(grp_idx_ff[g]));
         end
      end
   end

endmodule
